### sv/nfmt_pkg.sv
// Package for the number-to-text formatter: command codes, ASCII constants,
// chunk geometry and the digit-to-character function.
// No dependencies.
`default_nettype none

package nfmt_pkg;

    // Characters packed into one output beat (1..8)
    localparam int CHUNK_CHARS = 8;
    localparam int PCNT_W      = $clog2(CHUNK_CHARS + 1);

    // Conversion commands
    localparam logic [2:0] CMD_HEX  = 3'd0;
    localparam logic [2:0] CMD_BIN  = 3'd1;
    localparam logic [2:0] CMD_SDEC = 3'd2;
    localparam logic [2:0] CMD_UDEC = 3'd3;
    localparam logic [2:0] CMD_CHAR = 3'd4;

    // ASCII
    localparam logic [7:0] ASC_0     = 8'h30;
    localparam logic [7:0] ASC_A     = 8'h41;
    localparam logic [7:0] ASC_X     = 8'h78;
    localparam logic [7:0] ASC_B     = 8'h62;
    localparam logic [7:0] ASC_MINUS = 8'h2D;

    // Hex digit to uppercase ASCII; decimal digits map to '0'..'9'
    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10)
            c = ASC_0 + {4'h0, nib};
        else
            c = ASC_A + {4'h0, nib} - 8'd10;
        return c;
    endfunction

endpackage

`default_nettype wire

### sv/number_to_text_formatter_unit.sv
// Number-to-text formatter: hex, binary, signed/unsigned decimal and char
// conversion of one value, one character per cycle, packed into chunks.
// Depends on nfmt_pkg.
// Sequence: hex and binary strip leading zero digits, emit a 0x or 0b prefix
// and then the digits; decimal runs the shift-add-3 conversion, strips the
// leading zeros, emits a minus sign if negative and then the digits; char
// emits its single character. One item is in flight; the next input beat is
// taken the cycle after the final character.
// A waiting output beat stalls the character path until out_ready.
// Reset clears the sequencer, the packing register and the output valid flag.
`default_nettype none

module number_to_text_formatter_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  command,
    input  wire logic [63:0] value,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [63:0]      text_chunk,
    output logic [3:0]       char_count,
    output logic             last
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DABBLE,
        ST_SKIP,
        ST_PRE0,
        ST_PRE1,
        ST_DIGIT,
        ST_CHR
    } state_t;

    localparam int PW = nfmt_pkg::PCNT_W;

    state_t                 st_reg,    st_next;
    logic [2:0]             cmd_reg,   cmd_next;
    logic                   neg_reg,   neg_next;
    logic                   step4_reg, step4_next;
    logic [63:0]            shf_reg,   shf_next;
    logic [39:0]            bcd_reg,   bcd_next;
    logic [6:0]             dig_reg,   dig_next;
    logic [63:0]            pack_reg,  pack_next;
    logic [PW-1:0]          pcnt_reg,  pcnt_next;
    logic                   ov_reg,    ov_next;
    logic [63:0]            chunk_reg, chunk_next;
    logic [3:0]             cnt_reg,   cnt_next;
    logic                   last_reg,  last_next;

    logic        slot_free;
    logic        is_dec;
    logic [3:0]  top_dig;
    logic [63:0] shf_shift;
    logic [39:0] bcd_adj;
    logic [39:0] bcd_shift;
    logic [31:0] mag;
    logic        emit;
    logic [7:0]  ch;
    logic        ch_last;
    logic [63:0] lanes;
    logic        flush;

    assign in_ready   = (st_reg == ST_IDLE);
    assign out_valid  = ov_reg;
    assign text_chunk = chunk_reg;
    assign char_count = cnt_reg;
    assign last       = last_reg;

    // Datapath helpers
    assign slot_free = !ov_reg || out_ready;
    assign is_dec    = (cmd_reg == nfmt_pkg::CMD_SDEC) || (cmd_reg == nfmt_pkg::CMD_UDEC);
    assign top_dig   = step4_reg ? shf_reg[63:60] : {3'b000, shf_reg[63]};
    assign shf_shift = step4_reg ? {shf_reg[59:0], 4'h0} : {shf_reg[62:0], 1'b0};
    assign bcd_shift = {bcd_adj[38:0], shf_reg[63]};
    assign mag       = ((command == nfmt_pkg::CMD_SDEC) && value[31]) ?
                       (32'd0 - value[31:0]) : value[31:0];

    // Add-3 correction on each BCD digit, all in parallel
    always_comb
    begin
        for (int k = 0; k < 10; k++)
        begin
            if (bcd_reg[4*k +: 4] >= 4'd5)
                bcd_adj[4*k +: 4] = bcd_reg[4*k +: 4] + 4'd3;
            else
                bcd_adj[4*k +: 4] = bcd_reg[4*k +: 4];
        end
    end

    // Sequencer: one character per cycle while the output slot is free
    always_comb
    begin
        st_next    = st_reg;
        cmd_next   = cmd_reg;
        neg_next   = neg_reg;
        step4_next = step4_reg;
        shf_next   = shf_reg;
        bcd_next   = bcd_reg;
        dig_next   = dig_reg;
        emit       = 1'b0;
        ch         = 8'h00;
        ch_last    = 1'b0;

        unique case (st_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next = command;
                    neg_next = (command == nfmt_pkg::CMD_SDEC) && value[31];
                    unique case (command) inside
                        nfmt_pkg::CMD_HEX:
                        begin
                            shf_next   = value;
                            dig_next   = 7'd16;
                            step4_next = 1'b1;
                            st_next    = ST_SKIP;
                        end
                        nfmt_pkg::CMD_BIN:
                        begin
                            shf_next   = value;
                            dig_next   = 7'd64;
                            step4_next = 1'b0;
                            st_next    = ST_SKIP;
                        end
                        nfmt_pkg::CMD_SDEC, nfmt_pkg::CMD_UDEC:
                        begin
                            shf_next = {mag, 32'h0};
                            bcd_next = 40'h0;
                            dig_next = 7'd32;
                            st_next  = ST_DABBLE;
                        end
                        nfmt_pkg::CMD_CHAR:
                        begin
                            shf_next = {value[7:0], 56'h0};
                            st_next  = ST_CHR;
                        end
                        default:
                        begin
                            st_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DABBLE:
            begin
                bcd_next = bcd_shift;
                shf_next = {shf_reg[62:0], 1'b0};
                dig_next = dig_reg - 7'd1;
                if (dig_reg == 7'd1)
                begin
                    // BCD digits now go out as nibbles, like hex
                    shf_next   = {bcd_shift, 24'h0};
                    dig_next   = 7'd10;
                    step4_next = 1'b1;
                    st_next    = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if ((top_dig == 4'h0) && (dig_reg > 7'd1))
                begin
                    shf_next = shf_shift;
                    dig_next = dig_reg - 7'd1;
                end
                else if (is_dec && !neg_reg)
                    st_next = ST_DIGIT;
                else
                    st_next = ST_PRE0;
            end
            ST_PRE0:
            begin
                if (slot_free)
                begin
                    emit    = 1'b1;
                    ch      = neg_reg ? nfmt_pkg::ASC_MINUS : nfmt_pkg::ASC_0;
                    st_next = is_dec ? ST_DIGIT : ST_PRE1;
                end
            end
            ST_PRE1:
            begin
                if (slot_free)
                begin
                    emit    = 1'b1;
                    ch      = (cmd_reg == nfmt_pkg::CMD_HEX) ? nfmt_pkg::ASC_X
                                                              : nfmt_pkg::ASC_B;
                    st_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (slot_free)
                begin
                    emit     = 1'b1;
                    ch       = nfmt_pkg::hex_digit(top_dig);
                    shf_next = shf_shift;
                    dig_next = dig_reg - 7'd1;
                    if (dig_reg == 7'd1)
                    begin
                        ch_last = 1'b1;
                        st_next = ST_IDLE;
                    end
                end
            end
            ST_CHR:
            begin
                if (slot_free)
                begin
                    emit    = 1'b1;
                    ch      = shf_reg[63:56];
                    ch_last = 1'b1;
                    st_next = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    // Packing register and output beat
    always_comb
    begin
        lanes = pack_reg;
        for (int i = 0; i < nfmt_pkg::CHUNK_CHARS; i++)
        begin
            if (pcnt_reg == PW'(i))
                lanes[8*i +: 8] = ch;
        end
        flush = emit && (ch_last || (pcnt_reg == PW'(nfmt_pkg::CHUNK_CHARS - 1)));

        pack_next  = pack_reg;
        pcnt_next  = pcnt_reg;
        ov_next    = ov_reg && !out_ready;
        chunk_next = chunk_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;

        if (emit)
        begin
            if (flush)
            begin
                pack_next  = 64'h0;
                pcnt_next  = '0;
                ov_next    = 1'b1;
                chunk_next = lanes;
                cnt_next   = 4'(pcnt_reg) + 4'd1;
                last_next  = ch_last;
            end
            else
            begin
                pack_next = lanes;
                pcnt_next = pcnt_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_IDLE;
            pack_reg <= 64'h0;
            pcnt_reg <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            pack_reg <= pack_next;
            pcnt_reg <= pcnt_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        neg_reg   <= neg_next;
        step4_reg <= step4_next;
        shf_reg   <= shf_next;
        bcd_reg   <= bcd_next;
        dig_reg   <= dig_next;
        chunk_reg <= chunk_next;
        cnt_reg   <= cnt_next;
        last_reg  <= last_next;
    end

    // A beat always carries between one and CHUNK_CHARS characters
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> (cnt_reg != 4'd0) && (cnt_reg <= 4'(nfmt_pkg::CHUNK_CHARS)))
        else $error("char_count out of range");

    // Only the final beat of a text may be short
    a_short_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !last_reg) |-> (cnt_reg == 4'(nfmt_pkg::CHUNK_CHARS)))
        else $error("short beat not marked last");

    // Packer is empty whenever a new item can be taken
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_IDLE) |-> (pcnt_reg == '0))
        else $error("packer holds characters while idle");

    // Digit emission never runs with an empty digit count
    a_digit_count: assert property (@(posedge clk) disable iff (!rst_n)
        ((st_reg == ST_DIGIT) || (st_reg == ST_SKIP)) |-> (dig_reg != 7'd0))
        else $error("digit counter underflow");

endmodule

`default_nettype wire
